/* sv/mqbf_pkg.sv */
// ----------------------------------------------------------------------------
// mqbf_pkg
// Shared types and constants of the multi-queue byte fifo: operation and
// status codes, queue descriptor, command and result records.
// ----------------------------------------------------------------------------
package mqbf_pkg;

	localparam int BYTE_W    = 8;
	localparam int CAP_W     = 9;
	localparam int PTR_W     = CAP_W + 1;
	localparam int OP_W      = 3;
	localparam int Q_W       = 2;
	localparam int N_CAP     = 4;
	localparam int CFG_IDX_W = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 3'd0,
		OP_GET   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_FLUSH = 3'd3,
		OP_COPY  = 3'd4,
		OP_QUERY = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// per-queue ring state
	typedef struct packed {
		logic [CAP_W-1:0] rd_idx;
		logic [CAP_W-1:0] wr_idx;
		logic [CAP_W-1:0] fill;
	} desc_t;

	typedef struct packed {
		logic             en;
		logic [Q_W-1:0]   queue;
		desc_t            d;
	} desc_wr_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [Q_W-1:0]    queue;
		logic [BYTE_W-1:0] write_byte;
		logic [BYTE_W-1:0] peek_offset;
		logic [CAP_W-1:0]  copy_count;
		logic [Q_W-1:0]    target_queue;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		status_t           status;
		logic [CAP_W-1:0]  fill_level;
		logic [CAP_W-1:0]  free_space;
		logic [CAP_W-1:0]  queue_capacity;
		logic [CAP_W-1:0]  moved_count;
	} rsp_t;

endpackage

/* sv/mqbf_desc_mem.sv */
// ----------------------------------------------------------------------------
// mqbf_desc_mem
// Queue descriptor store: two registered read ports, one write port, and a
// valid bit per entry so that an entry never written reads as an empty queue.
// ----------------------------------------------------------------------------
module mqbf_desc_mem #(
	parameter int QUEUES = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [mqbf_pkg::Q_W-1:0] rd_a,
	input  logic [mqbf_pkg::Q_W-1:0] rd_b,
	output mqbf_pkg::desc_t       rdata_a,
	output mqbf_pkg::desc_t       rdata_b,
	input  mqbf_pkg::desc_wr_t    wr
);
	import mqbf_pkg::*;

	localparam int QAW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

	desc_t             entry_q [QUEUES];
	logic [QUEUES-1:0] valid_q;
	desc_t             rdata_a_q;
	desc_t             rdata_b_q;

	logic a_ok, b_ok, w_ok;

	assign a_ok = 32'(rd_a) < QUEUES;
	assign b_ok = 32'(rd_b) < QUEUES;
	assign w_ok = 32'(wr.queue) < QUEUES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en && w_ok) begin
			valid_q[QAW'(wr.queue)] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && w_ok) begin
			entry_q[QAW'(wr.queue)] <= wr.d;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_a_q <= (a_ok && valid_q[QAW'(rd_a)]) ? entry_q[QAW'(rd_a)] : '0;
			rdata_b_q <= (b_ok && valid_q[QAW'(rd_b)]) ? entry_q[QAW'(rd_b)] : '0;
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

/* sv/mqbf_byte_mem.sv */
// ----------------------------------------------------------------------------
// mqbf_byte_mem
// Shared byte store of all queues: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mqbf_byte_mem #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rdata,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/mqbf_seq.sv */
// ----------------------------------------------------------------------------
// mqbf_seq
// Operation sequencer: reads the descriptors, checks the request, drives the
// byte store and writes the descriptors back.
// ----------------------------------------------------------------------------
module mqbf_seq #(
	parameter int QUEUES      = 4,
	parameter int QUEUE_DEPTH = 256,
	parameter int ADDR_W      = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  mqbf_pkg::req_t            req,
	input  logic [mqbf_pkg::N_CAP-1:0][mqbf_pkg::CAP_W-1:0] capacity,
	output logic                      idle,
	output logic                      done,
	output mqbf_pkg::rsp_t            rsp,
	output logic                      desc_rd_en,
	output logic [mqbf_pkg::Q_W-1:0]  desc_rd_a,
	output logic [mqbf_pkg::Q_W-1:0]  desc_rd_b,
	input  mqbf_pkg::desc_t           desc_a,
	input  mqbf_pkg::desc_t           desc_b,
	output mqbf_pkg::desc_wr_t        desc_wr,
	output logic                      byte_rd_en,
	output logic [ADDR_W-1:0]         byte_rd_addr,
	input  logic [mqbf_pkg::BYTE_W-1:0] byte_rdata,
	output logic                      byte_wr_en,
	output logic [ADDR_W-1:0]         byte_wr_addr,
	output logic [mqbf_pkg::BYTE_W-1:0] byte_wr_data
);
	import mqbf_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DESC  = 9'b000000010,
		S_GETRD = 9'b000000100,
		S_PKMOD = 9'b000001000,
		S_PKRD  = 9'b000010000,
		S_CPRD  = 9'b000100000,
		S_CPWR  = 9'b001000000,
		S_CPWQ  = 9'b010000000,
		S_CPWT  = 9'b100000000
	} state_t;

	state_t           state_q, state_d;
	req_t             req_q, req_d;
	logic [PTR_W-1:0] ptr_q, ptr_d;
	logic [CAP_W-1:0] src_idx_q, src_idx_d;
	logic [CAP_W-1:0] dst_idx_q, dst_idx_d;
	logic [CAP_W-1:0] left_q, left_d;

	logic [CAP_W-1:0] cap, tcap;
	logic [PTR_W-1:0] peek_sum;
	logic             q_ok, t_ok, same;

	function automatic logic [CAP_W-1:0] eff_cap(logic [CAP_W-1:0] c);
		logic [CAP_W-1:0] r;
		r = c;
		if (c == '0) begin
			r = CAP_W'(1);
		end else if (32'(c) > QUEUE_DEPTH) begin
			r = CAP_W'(QUEUE_DEPTH);
		end
		return r;
	endfunction

	function automatic logic [CAP_W-1:0] advance(logic [CAP_W-1:0] idx, logic [CAP_W-1:0] c);
		logic [PTR_W-1:0] n;
		n = PTR_W'(idx) + PTR_W'(1);
		return (n >= PTR_W'(c)) ? '0 : n[CAP_W-1:0];
	endfunction

	function automatic logic [CAP_W-1:0] room(logic [CAP_W-1:0] c, logic [CAP_W-1:0] f);
		return (c > f) ? c - f : '0;
	endfunction

	function automatic logic [ADDR_W-1:0] slot(logic [Q_W-1:0] q, logic [PTR_W-1:0] idx);
		return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx);
	endfunction

	function automatic rsp_t mk_rsp(logic [BYTE_W-1:0] rb, status_t st, logic [CAP_W-1:0] f,
			logic [CAP_W-1:0] c, logic [CAP_W-1:0] mv);
		rsp_t r;
		r.read_byte      = rb;
		r.status         = st;
		r.fill_level     = f;
		r.free_space     = room(c, f);
		r.queue_capacity = c;
		r.moved_count    = mv;
		return r;
	endfunction

	assign idle      = (state_q == S_IDLE);
	assign desc_rd_a = req.queue;
	assign desc_rd_b = req.target_queue;

	// capacity is read live; the user must change it only while idle, which the block does not enforce
	assign cap  = eff_cap(capacity[req_q.queue]);
	assign tcap = eff_cap(capacity[req_q.target_queue]);
	assign q_ok = 32'(req_q.queue) < QUEUES;
	assign t_ok = 32'(req_q.target_queue) < QUEUES;
	assign same = (req_q.queue == req_q.target_queue);

	assign peek_sum = PTR_W'(desc_a.rd_idx) + PTR_W'(req_q.peek_offset);

	// desc_a and desc_b hold the descriptors for the whole transaction
	always_comb begin
		state_d      = state_q;
		req_d        = req_q;
		ptr_d        = ptr_q;
		src_idx_d    = src_idx_q;
		dst_idx_d    = dst_idx_q;
		left_d       = left_q;
		desc_rd_en   = 1'b0;
		desc_wr      = '0;
		byte_rd_en   = 1'b0;
		byte_rd_addr = '0;
		byte_wr_en   = 1'b0;
		byte_wr_addr = '0;
		byte_wr_data = '0;
		done         = 1'b0;
		rsp          = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d      = req;
					desc_rd_en = 1'b1;
					state_d    = S_DESC;
				end
			end
			S_DESC: begin
				state_d = S_IDLE;
				if (!q_ok) begin
					done = 1'b1;
				end else begin
					case (op_t'(req_q.op))
						OP_PUT: begin
							done = 1'b1;
							if (desc_a.fill < cap) begin
								byte_wr_en         = 1'b1;
								byte_wr_addr       = slot(req_q.queue, PTR_W'(desc_a.wr_idx));
								byte_wr_data       = req_q.write_byte;
								desc_wr.en         = 1'b1;
								desc_wr.queue      = req_q.queue;
								desc_wr.d.rd_idx   = desc_a.rd_idx;
								desc_wr.d.wr_idx   = advance(desc_a.wr_idx, cap);
								desc_wr.d.fill     = desc_a.fill + CAP_W'(1);
								rsp = mk_rsp('0, ST_OK, desc_a.fill + CAP_W'(1), cap, '0);
							end else begin
								rsp = mk_rsp('0, ST_FULL, desc_a.fill, cap, '0);
							end
						end
						OP_GET: begin
							if (desc_a.fill != '0) begin
								byte_rd_en       = 1'b1;
								byte_rd_addr     = slot(req_q.queue, PTR_W'(desc_a.rd_idx));
								desc_wr.en       = 1'b1;
								desc_wr.queue    = req_q.queue;
								desc_wr.d.rd_idx = advance(desc_a.rd_idx, cap);
								desc_wr.d.wr_idx = desc_a.wr_idx;
								desc_wr.d.fill   = desc_a.fill - CAP_W'(1);
								state_d          = S_GETRD;
							end else begin
								done = 1'b1;
								rsp  = mk_rsp('0, ST_EMPTY, desc_a.fill, cap, '0);
							end
						end
						OP_PEEK: begin
							if (desc_a.fill == '0) begin
								done = 1'b1;
								rsp  = mk_rsp('0, ST_EMPTY, desc_a.fill, cap, '0);
							end else if (CAP_W'(req_q.peek_offset) >= desc_a.fill) begin
								done = 1'b1;
								rsp  = mk_rsp('0, ST_RANGE, desc_a.fill, cap, '0);
							end else begin
								ptr_d   = (peek_sum >= PTR_W'(cap)) ? peek_sum - PTR_W'(cap)
									: peek_sum;
								state_d = S_PKMOD;
							end
						end
						OP_FLUSH: begin
							done          = 1'b1;
							desc_wr.en    = 1'b1;
							desc_wr.queue = req_q.queue;
							rsp           = mk_rsp('0, ST_OK, '0, cap, '0);
						end
						OP_COPY: begin
							if (!t_ok) begin
								done = 1'b1;
							end else if (desc_a.fill < req_q.copy_count) begin
								done = 1'b1;
								rsp  = mk_rsp('0, ST_EMPTY, desc_a.fill, cap, '0);
							end else if (room(tcap, desc_b.fill) < req_q.copy_count) begin
								done = 1'b1;
								rsp  = mk_rsp('0, ST_FULL, desc_a.fill, cap, '0);
							end else if (req_q.copy_count == '0) begin
								done = 1'b1;
								rsp  = mk_rsp('0, ST_OK, desc_a.fill, cap, '0);
							end else begin
								// same queue: both reads saw the same entry
								src_idx_d = desc_a.rd_idx;
								dst_idx_d = desc_b.wr_idx;
								left_d    = req_q.copy_count;
								state_d   = S_CPRD;
							end
						end
						default: begin
							done = 1'b1;
							rsp  = mk_rsp('0, ST_OK, desc_a.fill, cap, '0);
						end
					endcase
				end
			end
			S_GETRD: begin
				done    = 1'b1;
				rsp     = mk_rsp(byte_rdata, ST_OK, desc_a.fill - CAP_W'(1), cap, '0);
				state_d = S_IDLE;
			end
			S_PKMOD: begin
				// slot offset is the pointer modulo the queue region size
				if (32'(ptr_q) >= QUEUE_DEPTH) begin
					ptr_d = ptr_q - PTR_W'(QUEUE_DEPTH);
				end else begin
					byte_rd_en   = 1'b1;
					byte_rd_addr = slot(req_q.queue, ptr_q);
					state_d      = S_PKRD;
				end
			end
			S_PKRD: begin
				done    = 1'b1;
				rsp     = mk_rsp(byte_rdata, ST_OK, desc_a.fill, cap, '0);
				state_d = S_IDLE;
			end
			S_CPRD: begin
				byte_rd_en   = 1'b1;
				byte_rd_addr = slot(req_q.queue, PTR_W'(src_idx_q));
				src_idx_d    = advance(src_idx_q, cap);
				left_d       = left_q - CAP_W'(1);
				state_d      = S_CPWR;
			end
			S_CPWR: begin
				// write lands before the next read is issued, so no forwarding
				byte_wr_en   = 1'b1;
				byte_wr_addr = slot(req_q.target_queue, PTR_W'(dst_idx_q));
				byte_wr_data = byte_rdata;
				dst_idx_d    = advance(dst_idx_q, tcap);
				state_d      = (left_q == '0) ? S_CPWQ : S_CPRD;
			end
			S_CPWQ: begin
				desc_wr.en       = 1'b1;
				desc_wr.queue    = req_q.queue;
				desc_wr.d.rd_idx = src_idx_q;
				desc_wr.d.wr_idx = same ? dst_idx_q : desc_a.wr_idx;
				desc_wr.d.fill   = same ? desc_a.fill : desc_a.fill - req_q.copy_count;
				if (same) begin
					done    = 1'b1;
					rsp     = mk_rsp('0, ST_OK, desc_a.fill, cap, req_q.copy_count);
					state_d = S_IDLE;
				end else begin
					state_d = S_CPWT;
				end
			end
			S_CPWT: begin
				desc_wr.en       = 1'b1;
				desc_wr.queue    = req_q.target_queue;
				desc_wr.d.rd_idx = desc_b.rd_idx;
				desc_wr.d.wr_idx = dst_idx_q;
				desc_wr.d.fill   = desc_b.fill + req_q.copy_count;
				done             = 1'b1;
				rsp = mk_rsp('0, ST_OK, desc_a.fill - req_q.copy_count, cap, req_q.copy_count);
				state_d          = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q     <= req_d;
		ptr_q     <= ptr_d;
		src_idx_q <= src_idx_d;
		dst_idx_q <= dst_idx_d;
		left_q    <= left_d;
	end

endmodule

/* sv/multi_queue_byte_fifo.sv */
// ----------------------------------------------------------------------------
// multi_queue_byte_fifo
// Several byte ring queues in one shared memory, with put, get, peek, flush,
// copy and query, one result per command.
// ----------------------------------------------------------------------------
// One command is in flight at a time and each returns one result. Every
// command reads its descriptors first; put, flush, query and every refused
// command finish there. Get then reads its byte; peek folds QUEUE_DEPTH off
// the wrapped slot pointer until it lies in the queue region (only needed
// after a capacity change without a flush), then reads its byte. A copy
// moves each byte as a read and then a write on the byte store, then writes
// back the source descriptor and, between two queues, the target one.
// Descriptors reset through per-queue valid bits, so there is no clearing
// pass. The result register lets a new command in during the cycle its
// result is taken; capacity writes are always taken and must only be made
// while no command is in progress. Flush a queue after changing its capacity.
module multi_queue_byte_fifo #(
	parameter int QUEUES      = 4,
	parameter int QUEUE_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mqbf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mqbf_pkg::CAP_W-1:0]       cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// queue[1:0], write_byte[9:2], peek_offset[17:10], copy_count[26:18],
	// target_queue[28:27], zero fill
	input  logic [31:0]                      s_axis_tdata,
	// operation[2:0]
	input  logic [2:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// read_byte[7:0], fill_level[16:8], free_space[25:17],
	// queue_capacity[34:26], moved_count[43:35], zero fill
	output logic [47:0]                      m_axis_tdata,
	// status[1:0]
	output logic [1:0]                       m_axis_tuser
);
	import mqbf_pkg::*;

	localparam int DEPTH  = QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [N_CAP-1:0][CAP_W-1:0] capacity_q;
	logic                        out_valid_q;
	rsp_t                        rsp_q;

	req_t       req;
	rsp_t       rsp;
	logic       seq_idle, seq_done, start;
	logic       desc_rd_en;
	logic [Q_W-1:0] desc_rd_a, desc_rd_b;
	desc_t      desc_a, desc_b;
	desc_wr_t   desc_wr;
	logic       byte_rd_en, byte_wr_en;
	logic [ADDR_W-1:0] byte_rd_addr, byte_wr_addr;
	logic [BYTE_W-1:0] byte_rdata, byte_wr_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= {N_CAP{CAP_RESET}};
		end else if (cfg_valid && cfg_index < CFG_IDX_W'(N_CAP)) begin
			capacity_q[cfg_index[Q_W-1:0]] <= cfg_data;
		end
	end

	assign req.op           = s_axis_tuser;
	assign req.queue        = s_axis_tdata[1:0];
	assign req.write_byte   = s_axis_tdata[9:2];
	assign req.peek_offset  = s_axis_tdata[17:10];
	assign req.copy_count   = s_axis_tdata[26:18];
	assign req.target_queue = s_axis_tdata[28:27];

	// the result register is empty, or emptied now, before a new command starts
	assign s_axis_tready = seq_idle && (!out_valid_q || m_axis_tready);
	assign start         = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			rsp_q <= rsp;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, rsp_q.moved_count, rsp_q.queue_capacity,
		rsp_q.free_space, rsp_q.fill_level, rsp_q.read_byte};
	assign m_axis_tuser  = rsp_q.status;

	mqbf_seq #(
		.QUEUES      (QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ADDR_W      (ADDR_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req          (req),
		.capacity     (capacity_q),
		.idle         (seq_idle),
		.done         (seq_done),
		.rsp          (rsp),
		.desc_rd_en   (desc_rd_en),
		.desc_rd_a    (desc_rd_a),
		.desc_rd_b    (desc_rd_b),
		.desc_a       (desc_a),
		.desc_b       (desc_b),
		.desc_wr      (desc_wr),
		.byte_rd_en   (byte_rd_en),
		.byte_rd_addr (byte_rd_addr),
		.byte_rdata   (byte_rdata),
		.byte_wr_en   (byte_wr_en),
		.byte_wr_addr (byte_wr_addr),
		.byte_wr_data (byte_wr_data)
	);

	mqbf_desc_mem #(
		.QUEUES (QUEUES)
	) u_desc_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (desc_rd_en),
		.rd_a    (desc_rd_a),
		.rd_b    (desc_rd_b),
		.rdata_a (desc_a),
		.rdata_b (desc_b),
		.wr      (desc_wr)
	);

	mqbf_byte_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_byte_mem (
		.clk     (clk),
		.rd_en   (byte_rd_en),
		.rd_addr (byte_rd_addr),
		.rdata   (byte_rdata),
		.wr_en   (byte_wr_en),
		.wr_addr (byte_wr_addr),
		.wr_data (byte_wr_data)
	);

endmodule

/* sv/mqbf_checker.sv */
// ----------------------------------------------------------------------------
// mqbf_port_checks
// Port-level checks of the multi-queue byte fifo, bound to the top level.
// ----------------------------------------------------------------------------
module mqbf_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	import mqbf_pkg::*;

	logic [7:0] rb;
	logic [8:0] fill, free, cap, moved;

	assign rb    = m_axis_tdata[7:0];
	assign fill  = m_axis_tdata[16:8];
	assign free  = m_axis_tdata[25:17];
	assign cap   = m_axis_tdata[34:26];
	assign moved = m_axis_tdata[43:35];

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// one command at a time: no acceptance right after an acceptance
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("command accepted while one is in progress");

	// free space is capacity minus fill unless it saturated at zero
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (free == 9'd0 || ({1'b0, fill} + {1'b0, free}) == {1'b0, cap}))
		else $error("free space does not match fill and capacity");

	// data and moved bytes only come with a successful transaction
	a_ok_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (rb != 8'd0 || moved != 9'd0) |-> m_axis_tuser == ST_OK)
		else $error("data reported with a failing status");

endmodule

bind multi_queue_byte_fifo mqbf_port_checks u_mqbf_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
